// ----- design/fbsa_pkg.sv -----
// shared constants, the token type and a helper function of the fixed block size allocator
`timescale 1ns / 1ps
`default_nettype none
package fbsa_pkg;

    localparam int CLASS_COUNT   = 5;
    localparam int CLASS1_BLOCKS = 4;
    localparam int CLASS2_BLOCKS = 4;
    localparam int CLASS3_BLOCKS = 4;
    localparam int CLASS4_BLOCKS = 4;
    localparam int CLASS5_BLOCKS = 4;
    localparam int TOTAL_BLOCKS  = CLASS1_BLOCKS + CLASS2_BLOCKS + CLASS3_BLOCKS
                                 + CLASS4_BLOCKS + CLASS5_BLOCKS;

    localparam int OFS_W   = 16;
    localparam int CLS_W   = $clog2(CLASS_COUNT);
    localparam int PADDR_W = 5;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // register indexes
    localparam logic [2:0] REG_CLASS1 = 3'd0;
    localparam logic [2:0] REG_CLASS2 = 3'd1;
    localparam logic [2:0] REG_CLASS3 = 3'd2;
    localparam logic [2:0] REG_CLASS4 = 3'd3;
    localparam logic [2:0] REG_CLASS5 = 3'd4;

    localparam logic [OFS_W-1:0] CLASS1_RESET = 16'd8;
    localparam logic [OFS_W-1:0] CLASS2_RESET = 16'd16;
    localparam logic [OFS_W-1:0] CLASS3_RESET = 16'd32;
    localparam logic [OFS_W-1:0] CLASS4_RESET = 16'd64;
    localparam logic [OFS_W-1:0] CLASS5_RESET = 16'd128;

    // request travelling down the row of cells
    typedef struct packed {
        logic             valid;
        logic             cmd;
        logic [OFS_W-1:0] want;
        logic [OFS_W-1:0] where;
        logic [OFS_W-1:0] offset;
        logic             done;
        logic             success;
        logic [OFS_W-1:0] granted;
    } token_t;

    // size class of a block given its place in pool order
    function automatic logic [CLS_W-1:0] class_of(input int blk);
        int bounds [CLASS_COUNT];
        int acc;
        logic [CLS_W-1:0] cls;
        bounds[0] = CLASS1_BLOCKS;
        bounds[1] = CLASS2_BLOCKS;
        bounds[2] = CLASS3_BLOCKS;
        bounds[3] = CLASS4_BLOCKS;
        bounds[4] = CLASS5_BLOCKS;
        acc = 0;
        cls = CLS_W'(CLASS_COUNT - 1);
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            acc = 0;
            for (int j = 0; j <= c; j++) begin
                acc = acc + bounds[j];
            end
            if (blk < acc) begin
                cls = CLS_W'(c);
            end
        end
        return cls;
    endfunction

endpackage
`default_nettype wire

// ----- design/fbsa_cell.sv -----
// one block of the pool: busy bit plus one stage of the request row
`timescale 1ns / 1ps
`default_nettype none
module fbsa_cell
    import fbsa_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [OFS_W-1:0] size_i,
    input  wire token_t           tok_i,
    output token_t                tok_o
);

    logic   busy_reg, busy_next;
    logic   vld_reg;
    token_t tok_reg, tok_next;
    logic [OFS_W:0] sum;

    // match this block against the passing request
    always_comb begin
        busy_next = busy_reg;
        tok_next  = tok_i;
        sum       = {1'b0, tok_i.offset} + {1'b0, size_i};
        tok_next.offset = sum[OFS_W-1:0];
        if (tok_i.valid && !tok_i.done) begin
            if (tok_i.cmd == CMD_ALLOC) begin
                if (!busy_reg && (size_i >= tok_i.want)) begin
                    busy_next        = 1'b1;
                    tok_next.done    = 1'b1;
                    tok_next.success = 1'b1;
                    tok_next.granted = tok_i.offset;
                end
            end else begin
                if (busy_reg && (tok_i.offset == tok_i.where)) begin
                    busy_next        = 1'b0;
                    tok_next.done    = 1'b1;
                    tok_next.success = 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            vld_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            vld_reg  <= tok_i.valid;
        end
    end

    // payload stage
    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
    end

    always_comb begin
        tok_o       = tok_reg;
        tok_o.valid = vld_reg;
    end

endmodule
`default_nettype wire

// ----- design/fixed_block_size_allocator_unit.sv -----
// top level: config registers, request injection, cell row and result stage
`timescale 1ns / 1ps
`default_nettype none
// Each item (allocate or free) is accepted when the unit is idle and then walks
// down a row of TOTAL_BLOCKS cells (20 here), one cell per cycle; each cell holds
// one block's busy bit and adds its block size to the running offset. The result
// is caught in a hold register at the end of the row and then moved into the
// output register, which waits while that register is full and m_tready is low.
// A new item is taken only after the result has moved on, so items never overlap.
// Allocate takes the first free block whose class size is at least request_bytes;
// free clears the first busy block starting at release_offset. Offsets wrap at
// 16 bits. Sizes may be rewritten while idle; busy bits are kept.
module fixed_block_size_allocator_unit
    import fbsa_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // apb configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    // request stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [31:0]        s_tdata,   // [15:0] request_bytes, [31:16] release_offset
    input  wire logic               s_tuser,   // [0] cmd
    // result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [23:0]        m_tdata    // [0] success, [16:1] granted_offset, rest 0
);

    logic [OFS_W-1:0] size_reg [CLASS_COUNT];
    logic [2:0]       widx;
    logic             wr_en;

    logic             active_reg, active_next;
    logic             fin_vld_reg, fin_vld_next;
    logic             fin_ok_reg;
    logic [OFS_W-1:0] fin_ofs_reg;
    logic             out_vld_reg, out_vld_next;
    logic             out_ok_reg;
    logic [OFS_W-1:0] out_ofs_reg;
    logic             s_acc, fin_move;

    token_t                  tok [TOTAL_BLOCKS+1];
    logic [TOTAL_BLOCKS-1:0] tok_vld;

    // configuration registers
    assign pready = 1'b1;
    assign widx   = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg[REG_CLASS1] <= CLASS1_RESET;
            size_reg[REG_CLASS2] <= CLASS2_RESET;
            size_reg[REG_CLASS3] <= CLASS3_RESET;
            size_reg[REG_CLASS4] <= CLASS4_RESET;
            size_reg[REG_CLASS5] <= CLASS5_RESET;
        end else if (wr_en) begin
            case (widx)
                REG_CLASS1: size_reg[REG_CLASS1] <= pwdata[OFS_W-1:0];
                REG_CLASS2: size_reg[REG_CLASS2] <= pwdata[OFS_W-1:0];
                REG_CLASS3: size_reg[REG_CLASS3] <= pwdata[OFS_W-1:0];
                REG_CLASS4: size_reg[REG_CLASS4] <= pwdata[OFS_W-1:0];
                REG_CLASS5: size_reg[REG_CLASS5] <= pwdata[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (widx)
            REG_CLASS1: prdata = {16'd0, size_reg[REG_CLASS1]};
            REG_CLASS2: prdata = {16'd0, size_reg[REG_CLASS2]};
            REG_CLASS3: prdata = {16'd0, size_reg[REG_CLASS3]};
            REG_CLASS4: prdata = {16'd0, size_reg[REG_CLASS4]};
            REG_CLASS5: prdata = {16'd0, size_reg[REG_CLASS5]};
            default:    prdata = 32'd0;
        endcase
    end

    // request injection at the head of the row
    assign s_tready = !active_reg;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        tok[0].valid   = s_acc;
        tok[0].cmd     = s_tuser;
        tok[0].want    = s_tdata[15:0];
        tok[0].where   = s_tdata[31:16];
        tok[0].offset  = '0;
        tok[0].done    = 1'b0;
        tok[0].success = 1'b0;
        tok[0].granted = '0;
    end

    // row of block cells
    for (genvar i = 0; i < TOTAL_BLOCKS; i++) begin : g_cell
        localparam logic [CLS_W-1:0] CI = class_of(i);
        fbsa_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .size_i  (size_reg[CI]),
            .tok_i   (tok[i]),
            .tok_o   (tok[i+1])
        );
        assign tok_vld[i] = tok[i+1].valid;
    end

    // result hold and output register
    assign fin_move = fin_vld_reg && (!out_vld_reg || m_tready);

    always_comb begin
        active_next  = active_reg;
        fin_vld_next = fin_vld_reg;
        out_vld_next = out_vld_reg;
        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end
        if (fin_move) begin
            out_vld_next = 1'b1;
            fin_vld_next = 1'b0;
            active_next  = 1'b0;
        end
        if (tok[TOTAL_BLOCKS].valid) begin
            fin_vld_next = 1'b1;
        end
        if (s_acc) begin
            active_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            fin_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            fin_vld_reg <= fin_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok[TOTAL_BLOCKS].valid) begin
            fin_ok_reg  <= tok[TOTAL_BLOCKS].success;
            fin_ofs_reg <= tok[TOTAL_BLOCKS].granted;
        end
        if (fin_move) begin
            out_ok_reg  <= fin_ok_reg;
            out_ofs_reg <= fin_ofs_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_ofs_reg, out_ok_reg};

`ifndef SYNTHESIS
    // only one request walks the row at a time
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vld))
        else $error("more than one request in the cell row");

    // an accepted item enters the first cell next cycle
    a_inject: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> tok[1].valid)
        else $error("accepted item did not enter the row");

    // a held result belongs to the item in flight
    a_fin_active: assert property (@(posedge aclk) disable iff (!aresetn)
        fin_vld_reg |-> active_reg)
        else $error("held result with no item in flight");

    // a failed result carries a zero offset
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[16:1] == 16'd0))
        else $error("failed result with nonzero offset");
`endif

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// self-checking testbench for the fixed block size allocator unit
`timescale 1ns / 1ps
module tb;
    import fbsa_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REG_SLOTS     = 8;      // word slots reachable through paddr
    localparam int STALL_CYCLES  = 300;
    localparam int SETTLE_CYCLES = TOTAL_BLOCKS + 10;
    localparam int CHUNK_ITEMS   = 115;

    localparam logic [CLASS_COUNT-1:0][OFS_W-1:0] RESET_SIZES =
        {CLASS5_RESET, CLASS4_RESET, CLASS3_RESET, CLASS2_RESET, CLASS1_RESET};

    typedef struct {
        logic             cmd;
        logic             success;
        logic [OFS_W-1:0] offset;
    } grant_t;

    // clock, reset and block ports
    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata  = '0;    // [15:0] request_bytes, [31:16] release_offset
    logic               s_tuser  = 1'b0;  // [0] cmd
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;          // [0] success, [16:1] granted_offset

    // predictor state: sizes, pool layout and busy bits
    logic [OFS_W-1:0] class_size      [CLASS_COUNT];
    int               blocks_in_class [CLASS_COUNT];
    logic [OFS_W-1:0] blk_size        [TOTAL_BLOCKS];
    logic [OFS_W-1:0] blk_offset      [TOTAL_BLOCKS];
    logic             blk_busy        [TOTAL_BLOCKS];
    grant_t           pending_grants  [$];

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    bit   long_hold     = 1'b0;
    event start_long_stall;
    int   cycle_count   = 0;
    int   failures      = 0;
    int   grants        = 0;
    int   grant_misses  = 0;
    int   releases      = 0;
    int   release_misses = 0;
    int   config_sets   = 0;

    fixed_block_size_allocator_unit u_dut (
        .aclk, .aresetn,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // offsets and sizes of every block from the current class sizes
    function automatic void rebuild_layout();
        logic [OFS_W-1:0] acc;
        int b;
        acc = '0;
        b   = 0;
        for (int c = 0; c < CLASS_COUNT; c++) begin
            for (int k = 0; k < blocks_in_class[c]; k++) begin
                blk_size[b]   = class_size[c];
                blk_offset[b] = acc;
                acc = acc + class_size[c];
                b++;
            end
        end
    endfunction

    // first-fit allocate or first-match free, updating the busy bits
    function automatic grant_t apply_request(input logic cmd, input logic [OFS_W-1:0] want,
                                             input logic [OFS_W-1:0] where);
        grant_t r;
        r.cmd     = cmd;
        r.success = 1'b0;
        r.offset  = '0;
        for (int b = 0; b < TOTAL_BLOCKS && !r.success; b++) begin
            if (cmd == CMD_ALLOC && !blk_busy[b] && blk_size[b] >= want) begin
                blk_busy[b] = 1'b1;
                r.success   = 1'b1;
                r.offset    = blk_offset[b];
            end else if (cmd == CMD_FREE && blk_busy[b] && blk_offset[b] == where) begin
                blk_busy[b] = 1'b0;
                r.success   = 1'b1;
            end
        end
        return r;
    endfunction

    // offer one item, with a random gap, and predict it once accepted
    task automatic send_request(input logic cmd, input logic [OFS_W-1:0] want,
                                input logic [OFS_W-1:0] where);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {where, want};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_grants.push_back(apply_request(cmd, want, where));
    endtask

    // sender pauses until every outstanding result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge aclk);
    endtask

    // apb write: setup and access phases, then the bus returns to idle
    task automatic write_register(input int idx, input logic [OFS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 4);
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < CLASS_COUNT) begin
            class_size[idx] = value;
            rebuild_layout();
        end
        @(posedge aclk);
    endtask

    // apb read of one size register, compared with the predicted value
    task automatic check_register(input int idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(idx * 4);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== 32'(class_size[idx])) begin
            $error("prdata[%0d]: expected %0d, got %0d", idx, class_size[idx], prdata);
            failures++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // write all size registers and read them back
    task automatic set_class_sizes(input logic [CLASS_COUNT-1:0][OFS_W-1:0] sizes);
        for (int c = 0; c < CLASS_COUNT; c++) write_register(REG_CLASS1 + c, sizes[c]);
        for (int c = 0; c < CLASS_COUNT; c++) check_register(REG_CLASS1 + c);
        config_sets++;
    endtask

    task automatic random_class_sizes();
        logic [CLASS_COUNT-1:0][OFS_W-1:0] sizes;
        int style;
        style = $urandom_range(4);
        for (int c = 0; c < CLASS_COUNT; c++) begin
            case (style)
                0:       sizes[c] = RESET_SIZES[c];
                1:       sizes[c] = OFS_W'($urandom_range(64, 1));
                2:       sizes[c] = OFS_W'($urandom_range(65535, 1));
                3:       sizes[c] = $urandom_range(1) ? 16'hFFFF : 16'h0001;
                default: sizes[c] = OFS_W'($urandom_range(16384, 12000));  // offsets wrap
            endcase
        end
        set_class_sizes(sizes);
    endtask

    // mostly sensible allocates and frees of busy blocks, some raw noise
    task automatic random_traffic(input int count);
        int roll;
        int c;
        int pick;
        int busy_list [$];
        logic cmd;
        logic [OFS_W-1:0] want;
        logic [OFS_W-1:0] where;
        for (int n = 0; n < count; n++) begin
            roll  = $urandom_range(99);
            want  = OFS_W'($urandom);
            where = OFS_W'($urandom);
            if (roll < 15) begin
                cmd = 1'($urandom_range(1));
            end else if (roll < 57) begin
                cmd = CMD_ALLOC;
                c   = $urandom_range(CLASS_COUNT - 1);
                case ($urandom_range(3))
                    0:       want = class_size[c];
                    1:       want = class_size[c] + 1'b1;
                    2:       want = OFS_W'($urandom_range(class_size[c]));
                    default: want = OFS_W'($urandom_range(8));
                endcase
            end else begin
                cmd = CMD_FREE;
                busy_list.delete();
                for (int b = 0; b < TOTAL_BLOCKS; b++) begin
                    if (blk_busy[b]) busy_list.push_back(b);
                end
                if (busy_list.size() != 0) begin
                    pick = busy_list[$urandom_range(busy_list.size() - 1)];
                end else begin
                    pick = $urandom_range(TOTAL_BLOCKS - 1);
                end
                where = blk_offset[pick];
            end
            send_request(cmd, want, where);
        end
    endtask

    task automatic test_reset_values();
        for (int c = 0; c < CLASS_COUNT; c++) check_register(REG_CLASS1 + c);
    endtask

    task automatic test_directed_requests();
        send_request(CMD_ALLOC, 16'd0, 16'hFFFF);                 // zero bytes fits the first block
        send_request(CMD_ALLOC, CLASS1_RESET, 16'h0000);          // exact fit
        send_request(CMD_ALLOC, CLASS1_RESET + 16'd1, 16'h0000);  // spills into class two
        send_request(CMD_ALLOC, CLASS5_RESET, 16'h0000);          // only the last class fits
        send_request(CMD_ALLOC, CLASS5_RESET + 16'd1, 16'h0000);  // too big for any block
        send_request(CMD_ALLOC, 16'hFFFF, 16'hFFFF);
        send_request(CMD_FREE, 16'hFFFF, CLASS1_RESET);
        send_request(CMD_FREE, 16'h0000, CLASS1_RESET);           // already free
        send_request(CMD_FREE, 16'h0000, 16'd1);                  // not a block start
        send_request(CMD_FREE, 16'h0000, 16'hFFFF);
        send_request(CMD_FREE, 16'h0000, OFS_W'(4 * CLASS1_RESET));
        wait_for_results();
    endtask

    task automatic test_size_extremes();
        // largest sizes: offsets wrap downward from zero
        set_class_sizes({CLASS_COUNT{16'hFFFF}});
        send_request(CMD_ALLOC, 16'hFFFF, 16'h0000);
        send_request(CMD_FREE, 16'h0000, 16'hFFFF);
        send_request(CMD_FREE, 16'h0000, 16'hFFF0);
        send_request(CMD_ALLOC, 16'h0001, 16'h0000);
        wait_for_results();
        // smallest sizes
        set_class_sizes({CLASS_COUNT{16'h0001}});
        send_request(CMD_ALLOC, 16'h0001, 16'h0000);
        send_request(CMD_FREE, 16'h0000, 16'd19);
        send_request(CMD_FREE, 16'h0000, 16'h0000);
        wait_for_results();
        // every fourth block lands on the same wrapped offset
        set_class_sizes({CLASS_COUNT{16'h4000}});
        repeat (4) send_request(CMD_ALLOC, 16'h4000, 16'h0000);
        send_request(CMD_FREE, 16'h0000, 16'h0000);
        send_request(CMD_FREE, 16'h0000, 16'h0000);
        wait_for_results();
        // unused register slots must leave the sizes alone
        for (int idx = CLASS_COUNT; idx < REG_SLOTS; idx++) write_register(idx, 16'h0001);
        for (int c = 0; c < CLASS_COUNT; c++) check_register(REG_CLASS1 + c);
        send_request(CMD_ALLOC, 16'h4000, 16'h0000);
        wait_for_results();
    endtask

    task automatic test_random_phase(input int sender_pct, input int receiver_pct,
                                     input int count);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int done_items = 0; done_items < count; done_items += CHUNK_ITEMS) begin
            random_class_sizes();
            random_traffic(CHUNK_ITEMS);
            wait_for_results();
        end
    endtask

    // result side held off while the sender keeps offering
    task automatic test_output_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        -> start_long_stall;
        random_traffic(12);
        wait_for_results();
    endtask

    // long receiver hold-off, counted here
    always begin
        @(start_long_stall);
        long_hold <= 1'b1;
        repeat (STALL_CYCLES) @(posedge aclk);
        long_hold <= 1'b0;
    end

    // random receiver stalls
    always @(posedge aclk) begin
        m_tready <= !long_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // compare each result item with the oldest prediction
    always @(posedge aclk) begin : result_check
        grant_t exp_r;
        if (m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                $error("result item with nothing outstanding: success %0b offset %0d",
                       m_tdata[0], m_tdata[16:1]);
                failures++;
            end else begin
                exp_r = pending_grants.pop_front();
                if (m_tdata[0] !== exp_r.success) begin
                    $error("success: expected %0b, got %0b", exp_r.success, m_tdata[0]);
                    failures++;
                end
                if (m_tdata[16:1] !== exp_r.offset) begin
                    $error("granted_offset: expected %0d, got %0d", exp_r.offset,
                           m_tdata[16:1]);
                    failures++;
                end
                if (exp_r.cmd == CMD_ALLOC) begin
                    if (exp_r.success) grants++;
                    else grant_misses++;
                end else begin
                    if (exp_r.success) releases++;
                    else release_misses++;
                end
            end
        end
    end

    // watchdog
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        blocks_in_class[0] = CLASS1_BLOCKS;
        blocks_in_class[1] = CLASS2_BLOCKS;
        blocks_in_class[2] = CLASS3_BLOCKS;
        blocks_in_class[3] = CLASS4_BLOCKS;
        blocks_in_class[4] = CLASS5_BLOCKS;
        for (int c = 0; c < CLASS_COUNT; c++) class_size[c] = RESET_SIZES[c];
        for (int b = 0; b < TOTAL_BLOCKS; b++) blk_busy[b] = 1'b0;
        rebuild_layout();
        send_idle_pct = 23;
        recv_idle_pct = 55;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_directed_requests();
        test_size_extremes();
        test_random_phase(23, 55, 575);
        test_output_stall();
        test_random_phase(55, 23, 575);
        test_random_phase(0, 0, 575);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d grants, %0d allocate misses, %0d frees, %0d frees not found",
                 grants, grant_misses, releases, release_misses);
        $display("%0d size settings incl. wrapping offsets, random stalls, long output hold",
                 config_sets);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/fbsa_pkg.sv
design/fbsa_cell.sv
design/fixed_block_size_allocator_unit.sv
verif/tb.sv
